// ===== design/avt_pkg.sv =====
// Shared types and codes for the affine vertex transform engine.
package avt_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned MAT_ELEMS = 12;
  localparam int unsigned AXES      = 3;

  typedef logic [2:0]               req_t;
  typedef logic [3:0]               elem_idx_t;
  typedef logic signed [DATA_W-1:0] word_t;

  localparam req_t REQ_LOAD    = 3'd0;
  localparam req_t REQ_FWD_PT  = 3'd1;
  localparam req_t REQ_FWD_DIR = 3'd2;
  localparam req_t REQ_INV_PT  = 3'd3;
  localparam req_t REQ_INV_DIR = 3'd4;

  localparam elem_idx_t LAST_ELEM = 4'd11;

endpackage

// ===== design/avt_in_if.sv =====
// Request channel: valid/ready handshake with load and transform payload.
interface avt_in_if;
  logic                 valid;
  logic                 ready;
  avt_pkg::req_t        req_type;
  avt_pkg::elem_idx_t   elem_index;
  avt_pkg::word_t       elem_value;
  avt_pkg::word_t       in_x;
  avt_pkg::word_t       in_y;
  avt_pkg::word_t       in_z;

  modport source (
    output valid, req_type, elem_index, elem_value, in_x, in_y, in_z,
    input  ready
  );
  modport sink (
    input  valid, req_type, elem_index, elem_value, in_x, in_y, in_z,
    output ready
  );
endinterface

// ===== design/avt_out_if.sv =====
// Result channel: valid/ready handshake with transformed vector payload.
interface avt_out_if;
  logic           valid;
  logic           ready;
  avt_pkg::word_t out_x;
  avt_pkg::word_t out_y;
  avt_pkg::word_t out_z;
  logic           saturated;

  modport source (
    output valid, out_x, out_y, out_z, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, saturated,
    output ready
  );
endinterface

// ===== design/affine_vertex_transform.sv =====
// Affine vertex transform engine: 4x3 fixed-point matrix, four-stage pipeline.
// Takes one request per cycle while the result channel is not stalled; each
// request passes through the input register, operand select, nine parallel 33x32
// multipliers, and sum and saturate into the result register.
// Loads write one matrix element as they leave the input register and produce
// no result; requests with unused codes or a load index beyond eleven are
// dropped. The matrix resets to identity with zero translation. Each stage has
// its own valid bit, so a stalled result does not stop earlier stages filling.
module affine_vertex_transform #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  avt_in_if.sink           in_ch,
  avt_out_if.source        out_ch
);

  localparam int unsigned DW  = avt_pkg::DATA_W;
  localparam int unsigned OPW = DW + 1;
  localparam int unsigned FPW = OPW + DW;
  localparam int unsigned PW  = FPW - FRAC_BITS;
  localparam int unsigned SW  = PW + 2;
  localparam logic [DW-1:0] FIX_ONE = DW'(1) << FRAC_BITS;

  // stage enables
  logic en_a, en_b, en_c, en_d;

  // input register
  logic                a_v_r;
  avt_pkg::req_t       a_req_r;
  avt_pkg::elem_idx_t  a_idx_r;
  avt_pkg::word_t      a_val_r;
  avt_pkg::word_t      a_vec_r [3];

  // matrix
  logic [DW-1:0] mat_r [avt_pkg::MAT_ELEMS];

  // operand stage
  logic                  b_v_r;
  logic signed [OPW-1:0] b_d_r   [9];
  logic signed [DW-1:0]  b_a_r   [9];
  avt_pkg::word_t        b_add_r [3];

  // product stage
  logic                 c_v_r;
  logic signed [PW-1:0] c_p_r   [9];
  avt_pkg::word_t       c_add_r [3];

  // result register
  logic           out_v_r;
  avt_pkg::word_t out_vec_r [3];
  logic           out_sat_r;

  assign en_d = !out_v_r || out_ch.ready;
  assign en_c = !c_v_r || en_d;
  assign en_b = !b_v_r || en_c;
  assign en_a = !a_v_r || en_b;
  assign in_ch.ready = en_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (en_a) begin
      a_v_r <= in_ch.valid;
    end
    if (en_a && in_ch.valid) begin
      a_req_r    <= in_ch.req_type;
      a_idx_r    <= in_ch.elem_index;
      a_val_r    <= in_ch.elem_value;
      a_vec_r[0] <= in_ch.in_x;
      a_vec_r[1] <= in_ch.in_y;
      a_vec_r[2] <= in_ch.in_z;
    end
  end

  // request decode
  logic is_load, is_fwd, is_inv, is_pt, is_xform, mat_we;

  assign is_load  = (a_req_r == avt_pkg::REQ_LOAD);
  assign is_fwd   = (a_req_r == avt_pkg::REQ_FWD_PT) || (a_req_r == avt_pkg::REQ_FWD_DIR);
  assign is_inv   = (a_req_r == avt_pkg::REQ_INV_PT) || (a_req_r == avt_pkg::REQ_INV_DIR);
  assign is_pt    = (a_req_r == avt_pkg::REQ_FWD_PT) || (a_req_r == avt_pkg::REQ_INV_PT);
  assign is_xform = is_fwd || is_inv;
  assign mat_we   = a_v_r && en_b && is_load && (a_idx_r <= avt_pkg::LAST_ELEM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < int'(avt_pkg::MAT_ELEMS); i++) begin
        mat_r[i] <= ((i == 0) || (i == 4) || (i == 8)) ? FIX_ONE : '0;
      end
    end else if (mat_we) begin
      mat_r[a_idx_r] <= a_val_r;
    end
  end

  // operand select: product (c,k) feeds result component c
  logic signed [OPW-1:0] d_vec   [3];
  logic signed [OPW-1:0] b_d_nxt [9];
  logic signed [DW-1:0]  b_a_nxt [9];
  avt_pkg::word_t        b_add_nxt [3];

  for (genvar k = 0; k < 3; k++) begin : g_diff
    logic signed [OPW-1:0] p_ext;
    assign p_ext = (a_req_r == avt_pkg::REQ_INV_PT) ?
                   OPW'($signed(mat_r[9 + k])) : '0;
    assign d_vec[k] = OPW'(a_vec_r[k]) - p_ext;
  end

  for (genvar c = 0; c < 3; c++) begin : g_col
    assign b_add_nxt[c] = (is_fwd && is_pt) ? $signed(mat_r[9 + c]) : '0;
    for (genvar k = 0; k < 3; k++) begin : g_term
      assign b_d_nxt[c*3 + k] = is_inv ? d_vec[k] : OPW'(a_vec_r[k]);
      assign b_a_nxt[c*3 + k] = is_inv ? $signed(mat_r[c*3 + k]) :
                                         $signed(mat_r[k*3 + c]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (en_b) begin
      b_v_r <= a_v_r && is_xform;
    end
    if (en_b && a_v_r && is_xform) begin
      b_d_r   <= b_d_nxt;
      b_a_r   <= b_a_nxt;
      b_add_r <= b_add_nxt;
    end
  end

  // nine multipliers, floor to FRAC_BITS
  logic signed [PW-1:0] c_p_nxt [9];

  for (genvar i = 0; i < 9; i++) begin : g_mul
    logic signed [FPW-1:0] prod;
    assign prod       = FPW'(b_d_r[i]) * FPW'(b_a_r[i]);
    assign c_p_nxt[i] = prod[FPW-1:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (en_c) begin
      c_v_r <= b_v_r;
    end
    if (en_c && b_v_r) begin
      c_p_r   <= c_p_nxt;
      c_add_r <= b_add_r;
    end
  end

  // sum and saturate
  localparam logic signed [SW-1:0] S_MAX = SW'(32'sh7fff_ffff);
  localparam logic signed [SW-1:0] S_MIN = SW'(32'sh8000_0000);

  avt_pkg::word_t res_nxt [3];
  logic [2:0]     clip;

  for (genvar c = 0; c < 3; c++) begin : g_sum
    logic signed [SW-1:0] sum;
    assign sum = SW'(c_add_r[c]) + SW'(c_p_r[c*3]) + SW'(c_p_r[c*3 + 1])
               + SW'(c_p_r[c*3 + 2]);
    always_comb begin
      clip[c] = 1'b1;
      if (sum > S_MAX) begin
        res_nxt[c] = 32'sh7fff_ffff;
      end else if (sum < S_MIN) begin
        res_nxt[c] = 32'sh8000_0000;
      end else begin
        res_nxt[c] = sum[DW-1:0];
        clip[c]    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en_d) begin
      out_v_r <= c_v_r;
    end
    if (en_d && c_v_r) begin
      out_vec_r <= res_nxt;
      out_sat_r <= |clip;
    end
  end

  assign out_ch.valid     = out_v_r;
  assign out_ch.out_x     = out_vec_r[0];
  assign out_ch.out_y     = out_vec_r[1];
  assign out_ch.out_z     = out_vec_r[2];
  assign out_ch.saturated = out_sat_r;

  // a load or an unused code never reaches the operand stage
  a_drop_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (a_v_r && en_b && !is_xform) |=> !b_v_r)
    else $error("dropped request entered operand stage");

  // requests are refused only when every stage holds an item
  a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !en_a |-> (a_v_r && b_v_r && c_v_r && out_v_r))
    else $error("request refused with a free stage");

  // a finished sum moving on always becomes a result
  a_prod_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (c_v_r && en_d) |=> out_v_r)
    else $error("product stage item lost");

  // the matrix comes out of reset as identity
  a_reset_identity: assert property (@(posedge clk)
    ($past(!rst_n) && rst_n) |-> (mat_r[0] == FIX_ONE && mat_r[4] == FIX_ONE &&
                                  mat_r[8] == FIX_ONE && mat_r[9] == '0))
    else $error("matrix not identity after reset");

endmodule

// ===== bench/tb_affine_vertex_transform.sv =====
// Testbench for affine_vertex_transform: matrix loads and vertex transforms checked in order.
module tb_affine_vertex_transform;

  localparam int unsigned FRAC_BITS   = 16;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          STALL_LIMIT  = 3000;
  localparam int          REPORT_LIMIT = 10;

  localparam avt_pkg::word_t W_MAX = 32'sh7FFF_FFFF;
  localparam avt_pkg::word_t W_MIN = 32'sh8000_0000;
  localparam avt_pkg::word_t W_ONE = 32'sh0001_0000;
  localparam avt_pkg::req_t  REQ_CODE_MAX = '1;
  localparam avt_pkg::elem_idx_t IDX_MAX  = '1;
  localparam logic signed [79:0] WIDE_MAX = {{48{1'b0}}, 32'h7FFF_FFFF};
  localparam logic signed [79:0] WIDE_MIN = {{48{1'b1}}, 32'h8000_0000};

  typedef struct packed {
    avt_pkg::word_t x;
    avt_pkg::word_t y;
    avt_pkg::word_t z;
    logic           sat;
  } vertex_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  avt_in_if  in_ch();
  avt_out_if out_ch();

  affine_vertex_transform #(.FRAC_BITS(FRAC_BITS)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  avt_pkg::word_t shadow_matrix [avt_pkg::MAT_ELEMS];
  vertex_t expected_vertices [$];
  int      src_idle_pct  = 10;
  int      sink_idle_pct = 85;
  int      error_count   = 0;
  int      effective_requests = 0;
  int      quiet_cycles  = 0;

  // floor(d * a / 2^FRAC_BITS); arithmetic shift of a signed value rounds down
  function automatic logic signed [79:0] scaled_product(logic signed [79:0] d,
                                                        logic signed [79:0] a);
    logic signed [79:0] prod;
    prod = d * a;
    return prod >>> FRAC_BITS;
  endfunction

  function automatic avt_pkg::word_t clip_word(logic signed [79:0] v, inout logic sat);
    if (v > WIDE_MAX) begin
      sat = 1'b1;
      return W_MAX;
    end
    if (v < WIDE_MIN) begin
      sat = 1'b1;
      return W_MIN;
    end
    return avt_pkg::word_t'(v[31:0]);
  endfunction

  function automatic vertex_t transform_vertex(avt_pkg::req_t kind, avt_pkg::word_t x,
                                               avt_pkg::word_t y, avt_pkg::word_t z);
    logic signed [79:0] src [avt_pkg::AXES];
    logic signed [79:0] acc [avt_pkg::AXES];
    logic    sat;
    vertex_t res;
    src[0] = x;
    src[1] = y;
    src[2] = z;
    sat = 1'b0;
    if (kind == avt_pkg::REQ_FWD_PT || kind == avt_pkg::REQ_FWD_DIR) begin
      for (int c = 0; c < avt_pkg::AXES; c++) begin
        acc[c] = 0;
        if (kind == avt_pkg::REQ_FWD_PT) acc[c] = shadow_matrix[9 + c];
        acc[c] = acc[c] + scaled_product(src[0], shadow_matrix[c])
                        + scaled_product(src[1], shadow_matrix[3 + c])
                        + scaled_product(src[2], shadow_matrix[6 + c]);
      end
    end else begin
      // point difference kept at full width, not clipped
      if (kind == avt_pkg::REQ_INV_PT)
        for (int c = 0; c < avt_pkg::AXES; c++) src[c] = src[c] - shadow_matrix[9 + c];
      for (int c = 0; c < avt_pkg::AXES; c++)
        acc[c] = scaled_product(src[0], shadow_matrix[3 * c])
               + scaled_product(src[1], shadow_matrix[3 * c + 1])
               + scaled_product(src[2], shadow_matrix[3 * c + 2]);
    end
    res.x = clip_word(acc[0], sat);
    res.y = clip_word(acc[1], sat);
    res.z = clip_word(acc[2], sat);
    res.sat = sat;
    return res;
  endfunction

  function automatic avt_pkg::word_t rand_word();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return W_MAX;
          1: return W_MIN;
          2: return '0;
          3: return '1;
          default: return W_ONE;
        endcase
      end
      1, 2: return avt_pkg::word_t'($urandom);
      default: return avt_pkg::word_t'($urandom_range(0, 1 << 19))
                      - avt_pkg::word_t'(1 << 18);
    endcase
  endfunction

  task automatic note_error(string what, logic [31:0] want, logic [31:0] got);
    error_count++;
    if (error_count <= REPORT_LIMIT)
      $display("ERROR %t: %s expected %h got %h", $realtime, what, want, got);
  endtask

  // request monitor: keeps the matrix copy in step and queues expected vertices
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      case (in_ch.req_type)
        avt_pkg::REQ_LOAD: begin
          if (in_ch.elem_index <= avt_pkg::LAST_ELEM)
            shadow_matrix[in_ch.elem_index] = in_ch.elem_value;
        end
        avt_pkg::REQ_FWD_PT, avt_pkg::REQ_FWD_DIR,
        avt_pkg::REQ_INV_PT, avt_pkg::REQ_INV_DIR:
          expected_vertices.push_back(
            transform_vertex(in_ch.req_type, in_ch.in_x, in_ch.in_y, in_ch.in_z));
        default: ;
      endcase
    end
  end

  // result checker
  always @(posedge clk) begin
    vertex_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_vertices.size() == 0) begin
        note_error("unexpected result x", '0, out_ch.out_x);
      end else begin
        want = expected_vertices.pop_front();
        if (out_ch.out_x !== want.x) note_error("out_x", want.x, out_ch.out_x);
        if (out_ch.out_y !== want.y) note_error("out_y", want.y, out_ch.out_y);
        if (out_ch.out_z !== want.z) note_error("out_z", want.z, out_ch.out_z);
        if (out_ch.saturated !== want.sat)
          note_error("saturated", 32'(want.sat), 32'(out_ch.saturated));
      end
    end
  end

  always @(negedge clk)
    out_ch.ready = ($urandom_range(0, 99) >= sink_idle_pct);

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("affine_vertex_transform verification failed");
      $finish;
    end
  end

  task automatic send_request(avt_pkg::req_t kind, avt_pkg::elem_idx_t idx,
                              avt_pkg::word_t value, avt_pkg::word_t x,
                              avt_pkg::word_t y, avt_pkg::word_t z);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid      = 1'b1;
    in_ch.req_type   = kind;
    in_ch.elem_index = idx;
    in_ch.elem_value = value;
    in_ch.in_x       = x;
    in_ch.in_y       = y;
    in_ch.in_z       = z;
    do @(posedge clk); while (!in_ch.ready);
    if (!(kind > avt_pkg::REQ_INV_DIR ||
          (kind == avt_pkg::REQ_LOAD && idx > avt_pkg::LAST_ELEM)))
      effective_requests++;
    @(negedge clk);
  endtask

  task automatic load_elem(avt_pkg::elem_idx_t idx, avt_pkg::word_t value);
    send_request(avt_pkg::REQ_LOAD, idx, value, rand_word(), rand_word(), rand_word());
  endtask

  task automatic send_transform(avt_pkg::req_t kind, avt_pkg::word_t x,
                                avt_pkg::word_t y, avt_pkg::word_t z);
    send_request(kind, avt_pkg::elem_idx_t'($urandom), avt_pkg::word_t'($urandom),
                 x, y, z);
  endtask

  task automatic test_identity_transforms();
    send_transform(avt_pkg::REQ_FWD_PT,  W_MAX, W_MIN, '0);
    send_transform(avt_pkg::REQ_FWD_DIR, W_ONE, '1, W_MAX);
    send_transform(avt_pkg::REQ_INV_PT,  W_MIN, W_MAX, '1);
    send_transform(avt_pkg::REQ_INV_DIR, W_ONE, W_MIN, W_MAX);
  endtask

  task automatic test_matrix_extremes();
    avt_pkg::word_t vals [avt_pkg::MAT_ELEMS];
    vals = '{W_MIN, W_MAX, W_ONE, W_MAX, '0, -W_ONE, '0, '1, W_MIN, W_MAX, W_MIN, 32'sd1};
    for (int i = 0; i < avt_pkg::MAT_ELEMS; i++)
      load_elem(avt_pkg::elem_idx_t'(i), vals[i]);
    send_transform(avt_pkg::REQ_FWD_PT,  W_MAX, W_MAX, W_MAX);
    // difference against the translation row needs 33 bits
    send_transform(avt_pkg::REQ_INV_PT,  W_MIN, W_MAX, '0);
    send_transform(avt_pkg::REQ_FWD_DIR, 32'sd1, 32'sd1, 32'sd1);
  endtask

  task automatic test_ignored_requests();
    load_elem(avt_pkg::elem_idx_t'(int'(avt_pkg::LAST_ELEM) + 1), W_MAX);
    load_elem(IDX_MAX, W_MIN);
    for (int k = int'(avt_pkg::REQ_INV_DIR) + 1; k <= int'(REQ_CODE_MAX); k++)
      send_request(avt_pkg::req_t'(k), avt_pkg::elem_idx_t'($urandom), rand_word(),
                   rand_word(), rand_word(), rand_word());
    send_transform(avt_pkg::REQ_INV_DIR, '1, W_MIN, W_MAX);
  endtask

  // signed permutation of the axes, so inverse requests see orthonormal frames
  task automatic load_axis_frame();
    int             perm [avt_pkg::AXES];
    avt_pkg::word_t cell_val;
    perm[0] = $urandom_range(0, 2);
    perm[1] = (perm[0] + $urandom_range(1, 2)) % 3;
    perm[2] = 3 - perm[0] - perm[1];
    for (int r = 0; r < avt_pkg::AXES; r++)
      for (int c = 0; c < avt_pkg::AXES; c++) begin
        cell_val = '0;
        if (c == perm[r]) cell_val = $urandom_range(0, 1) ? W_ONE : -W_ONE;
        load_elem(avt_pkg::elem_idx_t'(3 * r + c), cell_val);
      end
  endtask

  task automatic test_random_stream(int src_pct, int sink_pct, int n);
    int target;
    int roll;
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    target = effective_requests + n;
    while (effective_requests < target) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        if ($urandom_range(0, 1))
          load_elem(avt_pkg::elem_idx_t'($urandom_range(int'(avt_pkg::LAST_ELEM) + 1,
                                                        int'(IDX_MAX))),
                    rand_word());
        else
          send_request(avt_pkg::req_t'($urandom_range(int'(avt_pkg::REQ_INV_DIR) + 1,
                                                      int'(REQ_CODE_MAX))),
                       avt_pkg::elem_idx_t'($urandom), rand_word(),
                       rand_word(), rand_word(), rand_word());
      end else if (roll < 20) begin
        load_elem(avt_pkg::elem_idx_t'($urandom_range(0, int'(avt_pkg::LAST_ELEM))),
                  rand_word());
      end else if (roll < 23) begin
        load_axis_frame();
      end else begin
        send_transform(avt_pkg::req_t'($urandom_range(int'(avt_pkg::REQ_FWD_PT),
                                                      int'(avt_pkg::REQ_INV_DIR))),
                       rand_word(), rand_word(), rand_word());
      end
    end
  endtask

  initial begin
    for (int i = 0; i < avt_pkg::MAT_ELEMS; i++) shadow_matrix[i] = '0;
    shadow_matrix[0] = W_ONE;
    shadow_matrix[4] = W_ONE;
    shadow_matrix[8] = W_ONE;
    in_ch.valid      = 1'b0;
    in_ch.req_type   = avt_pkg::REQ_LOAD;
    in_ch.elem_index = '0;
    in_ch.elem_value = '0;
    in_ch.in_x       = '0;
    in_ch.in_y       = '0;
    in_ch.in_z       = '0;
    out_ch.ready     = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_identity_transforms();
    test_matrix_extremes();
    test_ignored_requests();
    test_random_stream(10, 85, 540);
    test_random_stream(85, 10, 540);
    test_random_stream(0, 0, 540);

    in_ch.valid = 1'b0;
    while (expected_vertices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_vertices.size() != 0) error_count++;

    if (error_count == 0)
      $display("affine_vertex_transform verification clean");
    else
      $display("affine_vertex_transform verification failed");
    $finish;
  end

endmodule
